FILE: hw/rtl/ogn_pkg.sv
// ============================================================================
// ogn_pkg: shared constants and helpers for the octave gradient noise core
// Fixed-point format, register and function codes, gradient selection.
// ============================================================================
`default_nettype none

package ogn_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int PERM_AW    = 8;
    localparam int FRAC_W     = 16;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;

    // Fixed-point one in the widths where it is used.
    localparam logic signed [17:0] ONE_S18 = 18'sd65536;
    localparam logic [16:0]        ONE_U17 = 17'd65536;

    localparam int NOISE_W = 19;

    // Input function codes.
    localparam logic FUNC_REBUILD = 1'b0;
    localparam logic FUNC_NOISE   = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_SEED        = 2'd0;
    localparam logic [1:0] REG_OCTAVES     = 2'd1;
    localparam logic [1:0] REG_PERSISTENCE = 2'd2;

    localparam logic [31:0] SEED_RESET = 32'd12345;
    localparam logic [3:0]  OCT_RESET  = 4'd4;
    localparam logic [15:0] PERS_RESET = 16'd32768;

    // Gradient dot product for one of the four diagonal directions.
    function automatic logic signed [19:0] grad(input logic [1:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y);
        logic signed [19:0] xe;
        logic signed [19:0] ye;
        xe = 20'(x);
        ye = 20'(y);
        case (h)
            2'd0:    grad = xe + ye;
            2'd1:    grad = ye - xe;
            2'd2:    grad = xe - ye;
            default: grad = -xe - ye;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ogn_div.sv
// ============================================================================
// ogn_div: restoring divider, one quotient bit per cycle
// Gives quotient and remainder of an unsigned dividend by an unsigned divisor.
// ============================================================================
`default_nettype none

module ogn_div #(
    parameter int DVD_W = 39,
    parameter int DVS_W = 21
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              start,
    input  wire [DVD_W-1:0]  dividend,
    input  wire [DVS_W-1:0]  divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_sub;
    logic             fits;

    assign trial     = {rem_reg, quo_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/octave_gradient_noise_2d_core.sv
// ============================================================================
// octave_gradient_noise_2d_core: 2D gradient noise summed over octaves
// Rebuilds a shuffled permutation table or samples fractal gradient noise.
// ============================================================================
//
//  Channel   Direction  Payload
//  --------  ---------  ------------------------------------------------------
//  s_*       in         tuser: func; tdata: x_coord [31:0], y_coord [63:32]
//  m_*       out        tuser: result_kind; tdata: noise_value [18:0]
//  cfg_*     in         cfg_index selects the register, cfg_data is the value
//
//  A rebuild transfer runs 255 shuffle swaps, and the serial modulo for each
//  swap dominates. A noise transfer runs the fade, permutation and lerp
//  steps once per octave, then a final division normalizes the sum.
//  One multiplier and one serial divider are shared by all steps under
//  the sequencer.
//  Reset (aresetn low, synchronous) restores the identity permutation by
//  clearing one valid flag per table entry, and loads the register defaults.
//  s_tready is high only in the idle state; a finished result waits in the
//  output register while the next item is accepted.
//
`default_nettype none

module octave_gradient_noise_2d_core
    import ogn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Input item: tuser = func; tdata = x_coord [31:0], y_coord [63:32].
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [0:0]  s_tuser,
    input  wire  [63:0] s_tdata,
    // Result item: tuser = result_kind; tdata = noise_value [18:0], zeros above.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [0:0]  m_tuser,
    output logic [23:0] m_tdata,
    // Configuration write channel.
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data
);

    localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
    // A weighted octave term fits in 35 signed bits; the sum grows per octave.
    localparam int TOT_W  = 35 + OCT_W;
    localparam int NORM_W = 17 + OCT_W;

    // Sequencer state codes.
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CLR      = 5'd1;
    localparam logic [4:0] S_MOD_GO   = 5'd2;
    localparam logic [4:0] S_MOD_WAIT = 5'd3;
    localparam logic [4:0] S_RD_I     = 5'd4;
    localparam logic [4:0] S_RD_J     = 5'd5;
    localparam logic [4:0] S_WR_I     = 5'd6;
    localparam logic [4:0] S_WR_J     = 5'd7;
    localparam logic [4:0] S_F0       = 5'd8;
    localparam logic [4:0] S_F1       = 5'd9;
    localparam logic [4:0] S_F2       = 5'd10;
    localparam logic [4:0] S_F3       = 5'd11;
    localparam logic [4:0] S_P0       = 5'd12;
    localparam logic [4:0] S_P1       = 5'd13;
    localparam logic [4:0] S_P2       = 5'd14;
    localparam logic [4:0] S_P3       = 5'd15;
    localparam logic [4:0] S_P4       = 5'd16;
    localparam logic [4:0] S_P5       = 5'd17;
    localparam logic [4:0] S_P6       = 5'd18;
    localparam logic [4:0] S_L0       = 5'd19;
    localparam logic [4:0] S_L1       = 5'd20;
    localparam logic [4:0] S_L2       = 5'd21;
    localparam logic [4:0] S_L3       = 5'd22;
    localparam logic [4:0] S_L4       = 5'd23;
    localparam logic [4:0] S_L5       = 5'd24;
    localparam logic [4:0] S_L6       = 5'd25;
    localparam logic [4:0] S_L7       = 5'd26;
    localparam logic [4:0] S_D_GO     = 5'd27;
    localparam logic [4:0] S_D_WAIT   = 5'd28;
    localparam logic [4:0] S_OUT      = 5'd29;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    // Configuration registers.
    logic [31:0] seed_cfg_reg;
    logic [3:0]  oct_cfg_reg;
    logic [15:0] pers_cfg_reg;

    // Shuffle state.
    logic [31:0]        lcg_reg;
    logic [PERM_AW-1:0] idx_reg;
    logic [PERM_AW-1:0] j_reg;
    logic [PERM_AW-1:0] tmp_reg;

    // Noise state.
    logic [31:0]        x_reg;
    logic [31:0]        y_reg;
    logic [OCT_W-1:0]   oct_reg;
    logic [OCT_W-1:0]   oct_last;
    logic               fsel_reg;
    logic [15:0]        t2_reg;
    logic [16:0]        u_reg;
    logic [16:0]        v_reg;
    logic [PERM_AW-1:0] ca_reg;
    logic [PERM_AW-1:0] cb_reg;
    logic [1:0]         h_aa_reg;
    logic [1:0]         h_ba_reg;
    logic [1:0]         h_ab_reg;
    logic [1:0]         h_bb_reg;
    logic signed [19:0] l0_reg;
    logic signed [19:0] l1_reg;
    logic signed [19:0] noise_reg;
    logic [16:0]        amp_reg;
    logic signed [TOT_W-1:0] total_reg;
    logic [NORM_W-1:0]  norm_reg;
    logic               kind_reg;
    logic [NOISE_W-1:0] res_reg;

    // Shared multiplier.
    logic signed [20:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [38:0] mul_reg;

    // Permutation memory with a valid flag per entry; an invalid entry reads
    // as its own index, which is the identity table.
    logic [PERM_AW-1:0] perm_mem [TABLE_SIZE];
    logic               pvld_reg [TABLE_SIZE];
    logic [PERM_AW-1:0] perm_addr;
    logic               perm_we;
    logic [PERM_AW-1:0] perm_wdata;
    logic [PERM_AW-1:0] prd_data_reg;
    logic [PERM_AW-1:0] prd_addr_reg;
    logic               prd_vld_reg;
    logic [PERM_AW-1:0] perm_out;

    // Shared divider.
    logic              div_start;
    logic [TOT_W-1:0]  div_dvd;
    logic [NORM_W-1:0] div_dvs;
    logic              div_done;
    logic [TOT_W-1:0]  div_quo;
    logic [NORM_W-1:0] div_rem;

    // Output register.
    logic               m_tvalid_reg;
    logic               m_kind_reg;
    logic [NOISE_W-1:0] m_value_reg;

    // Datapath helpers.
    logic [15:0]        fade_f;
    logic [21:0]        fade_p;
    logic signed [17:0] fxe;
    logic signed [17:0] fye;
    logic signed [17:0] fxm;
    logic signed [17:0] fym;
    logic signed [19:0] g_aa;
    logic signed [19:0] g_ba;
    logic signed [19:0] g_ab;
    logic signed [19:0] g_bb;
    logic signed [22:0] mul_hi;
    logic               tot_neg;
    logic [NOISE_W-1:0] q_sat;
    logic               accept;
    logic               out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Octave count, treated as one when zero and capped at the maximum.
    always_comb begin
        if (oct_cfg_reg == 4'd0) begin
            oct_last = '0;
        end else if (32'(oct_cfg_reg) > MAX_OCTAVES) begin
            oct_last = OCT_W'(MAX_OCTAVES - 1);
        end else begin
            oct_last = OCT_W'(oct_cfg_reg - 4'd1);
        end
    end

    // Fade polynomial pieces: p = 6*t2 - 15*f + 10 in fixed point, always
    // positive over the fraction range.
    assign fade_f = fsel_reg ? y_reg[FRAC_W-1:0] : x_reg[FRAC_W-1:0];
    assign fade_p = ({6'd0, t2_reg} << 2) + ({6'd0, t2_reg} << 1)
                  - ({6'd0, fade_f} << 4) + {6'd0, fade_f} + 22'd655360;

    assign fxe = $signed({2'b00, x_reg[FRAC_W-1:0]});
    assign fye = $signed({2'b00, y_reg[FRAC_W-1:0]});
    assign fxm = fxe - ONE_S18;
    assign fym = fye - ONE_S18;

    assign g_aa = grad(h_aa_reg, fxe, fye);
    assign g_ba = grad(h_ba_reg, fxm, fye);
    assign g_ab = grad(h_ab_reg, fxe, fym);
    assign g_bb = grad(h_bb_reg, fxm, fym);

    // Product shifted down by the fraction, rounding toward minus infinity.
    assign mul_hi = $signed(mul_reg[38:FRAC_W]);

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_F0: begin
                mul_a = $signed({5'd0, fade_f});
                mul_b = $signed({2'd0, fade_f});
            end
            S_F1: begin
                mul_a = $signed({5'd0, mul_reg[31:16]});
                mul_b = $signed({2'd0, fade_f});
            end
            S_F2: begin
                mul_a = $signed(fade_p[20:0]);
                mul_b = $signed({2'd0, mul_reg[31:16]});
            end
            S_L0: begin
                mul_a = 21'(g_ba) - 21'(g_aa);
                mul_b = $signed({1'b0, u_reg});
            end
            S_L1: begin
                mul_a = 21'(g_bb) - 21'(g_ab);
                mul_b = $signed({1'b0, u_reg});
            end
            S_L3: begin
                mul_a = 21'(l1_reg) - 21'(l0_reg);
                mul_b = $signed({1'b0, v_reg});
            end
            S_L5: begin
                mul_a = 21'(noise_reg);
                mul_b = $signed({1'b0, amp_reg});
            end
            S_L6: begin
                mul_a = $signed({5'd0, pers_cfg_reg});
                mul_b = $signed({1'b0, amp_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
    end

    // Permutation memory port selection.
    always_comb begin
        perm_addr  = '0;
        perm_we    = 1'b0;
        perm_wdata = perm_out;
        unique case (state_reg)
            S_RD_I: perm_addr = idx_reg;
            S_RD_J: perm_addr = j_reg;
            S_WR_I: begin
                perm_addr  = idx_reg;
                perm_we    = 1'b1;
                perm_wdata = perm_out;
            end
            S_WR_J: begin
                perm_addr  = j_reg;
                perm_we    = 1'b1;
                perm_wdata = tmp_reg;
            end
            S_P0: perm_addr = x_reg[FRAC_W+PERM_AW-1:FRAC_W];
            S_P1: perm_addr = x_reg[FRAC_W+PERM_AW-1:FRAC_W] + 1'b1;
            S_P2: perm_addr = ca_reg;
            S_P3: perm_addr = cb_reg;
            S_P4: perm_addr = ca_reg + 1'b1;
            S_P5: perm_addr = cb_reg + 1'b1;
            default: perm_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (perm_we) begin
            perm_mem[perm_addr] <= perm_wdata;
        end
        prd_data_reg <= perm_mem[perm_addr];
        prd_addr_reg <= perm_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || state_reg == S_CLR) begin
            for (int k = 0; k < TABLE_SIZE; k++) begin
                pvld_reg[k] <= 1'b0;
            end
            prd_vld_reg <= 1'b0;
        end else begin
            if (perm_we) begin
                pvld_reg[perm_addr] <= 1'b1;
            end
            prd_vld_reg <= pvld_reg[perm_addr];
        end
    end

    assign perm_out = prd_vld_reg ? prd_data_reg : prd_addr_reg;

    // Divider operand selection: shuffle modulo or the final normalization.
    assign tot_neg   = total_reg[TOT_W-1];
    assign div_start = (state_reg == S_MOD_GO) || (state_reg == S_D_GO);
    always_comb begin
        if (state_reg == S_MOD_GO) begin
            div_dvd = TOT_W'(lcg_reg);
            div_dvs = NORM_W'({1'b0, idx_reg} + 9'd1);
        end else begin
            div_dvd = tot_neg ? TOT_W'(-total_reg) : TOT_W'(total_reg);
            div_dvs = norm_reg;
        end
    end

    ogn_div #(
        .DVD_W (TOT_W),
        .DVS_W (NORM_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Truncated quotient with sign restored, saturated to the result range.
    always_comb begin
        if (!tot_neg && div_quo > TOT_W'(262143)) begin
            q_sat = 19'h3FFFF;
        end else if (tot_neg && div_quo > TOT_W'(262144)) begin
            q_sat = 19'h40000;
        end else if (tot_neg) begin
            q_sat = 19'(-div_quo);
        end else begin
            q_sat = 19'(div_quo);
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser[0] == FUNC_REBUILD) ? S_CLR : S_F0;
                end
            end
            S_CLR:      state_next = S_MOD_GO;
            S_MOD_GO:   state_next = S_MOD_WAIT;
            S_MOD_WAIT: state_next = div_done ? S_RD_I : S_MOD_WAIT;
            S_RD_I:     state_next = S_RD_J;
            S_RD_J:     state_next = S_WR_I;
            S_WR_I:     state_next = S_WR_J;
            S_WR_J:     state_next = (idx_reg == 8'd1) ? S_OUT : S_MOD_GO;
            S_F0:       state_next = S_F1;
            S_F1:       state_next = S_F2;
            S_F2:       state_next = S_F3;
            S_F3:       state_next = fsel_reg ? S_P0 : S_F0;
            S_P0:       state_next = S_P1;
            S_P1:       state_next = S_P2;
            S_P2:       state_next = S_P3;
            S_P3:       state_next = S_P4;
            S_P4:       state_next = S_P5;
            S_P5:       state_next = S_P6;
            S_P6:       state_next = S_L0;
            S_L0:       state_next = S_L1;
            S_L1:       state_next = S_L2;
            S_L2:       state_next = S_L3;
            S_L3:       state_next = S_L4;
            S_L4:       state_next = S_L5;
            S_L5:       state_next = S_L6;
            S_L6:       state_next = S_L7;
            S_L7:       state_next = (oct_reg == oct_last) ? S_D_GO : S_F0;
            S_D_GO:     state_next = S_D_WAIT;
            S_D_WAIT:   state_next = div_done ? S_OUT : S_D_WAIT;
            S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_cfg_reg <= SEED_RESET;
            oct_cfg_reg  <= OCT_RESET;
            pers_cfg_reg <= PERS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SEED:        seed_cfg_reg <= cfg_data;
                REG_OCTAVES:     oct_cfg_reg  <= cfg_data[3:0];
                REG_PERSISTENCE: pers_cfg_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                kind_reg  <= s_tuser[0];
                x_reg     <= s_tdata[31:0];
                y_reg     <= s_tdata[63:32];
                oct_reg   <= '0;
                fsel_reg  <= 1'b0;
                amp_reg   <= ONE_U17;
                total_reg <= '0;
                norm_reg  <= '0;
                res_reg   <= '0;
            end
            S_CLR: begin
                lcg_reg <= seed_cfg_reg;
                idx_reg <= 8'd255;
            end
            S_MOD_GO: begin
                lcg_reg <= 32'(lcg_reg * LCG_MUL) + LCG_ADD;
            end
            S_MOD_WAIT: begin
                j_reg <= div_rem[PERM_AW-1:0];
            end
            S_RD_J: begin
                tmp_reg <= perm_out;
            end
            S_WR_J: begin
                idx_reg <= idx_reg - 1'b1;
            end
            S_F1: begin
                t2_reg <= mul_reg[31:16];
            end
            S_F3: begin
                // Fade is capped at one.
                if (mul_reg[38:FRAC_W] > 23'(ONE_U17)) begin
                    if (fsel_reg) v_reg <= ONE_U17;
                    else          u_reg <= ONE_U17;
                end else begin
                    if (fsel_reg) v_reg <= mul_reg[32:16];
                    else          u_reg <= mul_reg[32:16];
                end
                fsel_reg <= 1'b1;
            end
            S_P1: ca_reg   <= perm_out + y_reg[FRAC_W+PERM_AW-1:FRAC_W];
            S_P2: cb_reg   <= perm_out + y_reg[FRAC_W+PERM_AW-1:FRAC_W];
            S_P3: h_aa_reg <= perm_out[1:0];
            S_P4: h_ba_reg <= perm_out[1:0];
            S_P5: h_ab_reg <= perm_out[1:0];
            S_P6: h_bb_reg <= perm_out[1:0];
            S_L1: l0_reg   <= 20'(23'(g_aa) + mul_hi);
            S_L2: l1_reg   <= 20'(23'(g_ab) + mul_hi);
            S_L4: noise_reg <= 20'(23'(l0_reg) + mul_hi);
            S_L6: begin
                total_reg <= total_reg + TOT_W'(mul_reg);
                norm_reg  <= norm_reg + NORM_W'(amp_reg);
            end
            S_L7: begin
                amp_reg  <= mul_reg[32:16];
                x_reg    <= {x_reg[30:0], 1'b0};
                y_reg    <= {y_reg[30:0], 1'b0};
                fsel_reg <= 1'b0;
                oct_reg  <= oct_reg + 1'b1;
            end
            S_D_WAIT: begin
                if (div_done) begin
                    res_reg <= q_sat;
                end
            end
            default: ;
        endcase
    end

    // Output register: loaded when the result slot is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_kind_reg  <= kind_reg;
            m_value_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {5'd0, m_value_reg};

endmodule

`default_nettype wire
